FILE: hw/rtl/sds_pkg.sv
// Shared types and constants for the SCAN disk scheduler.
// No dependencies; every other file of the block imports this package.
package sds_pkg;

	localparam int MAX_REQUESTS = 32;
	localparam int CYL_BITS     = 16;
	localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
	localparam int ADDR_W       = $clog2(MAX_REQUESTS);
	localparam int MOV_W        = 17;
	localparam int SIZE_W       = 17;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 17;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DISK_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_HEAD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_RIGHT = 2'd2;

	// Settings seen by the controller for one run
	typedef struct packed {
		logic [CYL_BITS-1:0] end_cyl;
		logic [CYL_BITS-1:0] head;
		logic                right;
	} sds_cfg_t;

	// Store write port
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [CYL_BITS-1:0] data;
	} sds_wr_t;

	// Store read port
	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] addr;
	} sds_rd_t;

	// Controller status
	typedef struct packed {
		logic             sched;
		logic [CNT_W-1:0] cnt;
	} sds_stat_t;

endpackage

FILE: hw/rtl/sds_in_if.sv
// Request channel: one cylinder request per item.
// Depends on sds_pkg for the cylinder width.
interface sds_in_if;
	import sds_pkg::*;

	logic                valid;
	logic                ready;
	logic [CYL_BITS-1:0] cylinder;
	logic                last_request;

	modport source (output valid, output cylinder, output last_request, input ready);
	modport sink (input valid, input cylinder, input last_request, output ready);
endinterface

FILE: hw/rtl/sds_out_if.sv
// Result channel: one position of the seek sequence per item.
// Depends on sds_pkg for the field widths.
interface sds_out_if;
	import sds_pkg::*;

	logic                valid;
	logic                ready;
	logic [CYL_BITS-1:0] position;
	logic [MOV_W-1:0]    total_movement;
	logic                dropped;
	logic                final_step;

	modport source (output valid, output position, output total_movement, output dropped,
		output final_step, input ready);
	modport sink (input valid, input position, input total_movement, input dropped,
		input final_step, output ready);
endinterface

FILE: hw/rtl/sds_store.sv
// Request store: one write port, one read port, registered read data.
// Depends on sds_pkg for the port structs.
module sds_store (
	input  logic                         clk,
	input  sds_pkg::sds_wr_t             wr,
	input  sds_pkg::sds_rd_t             rd,
	output logic [sds_pkg::CYL_BITS-1:0] rdata
);
	import sds_pkg::*;

	logic [CYL_BITS-1:0] mem [MAX_REQUESTS];
	logic [CYL_BITS-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd.re) begin
			rdata_q <= mem[rd.addr];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: hw/rtl/sds_ctrl.sv
// Scheduler control: sorted insertion into the store, split count and
// sequence emission with the output register. Depends on sds_pkg and the
// channel interfaces.
module sds_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sds_pkg::sds_cfg_t            cfg,
	sds_in_if.sink                       req,
	sds_out_if.source                    res,
	output sds_pkg::sds_wr_t             wr,
	output sds_pkg::sds_rd_t             rd,
	input  logic [sds_pkg::CYL_BITS-1:0] rdata,
	output sds_pkg::sds_stat_t           stat
);
	import sds_pkg::*;

	localparam logic [1:0] S_LOAD = 2'd0;
	localparam logic [1:0] S_INS  = 2'd1;
	localparam logic [1:0] S_CNT  = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	localparam logic [1:0] PH_HEAD  = 2'd0;
	localparam logic [1:0] PH_FIRST = 2'd1;
	localparam logic [1:0] PH_END   = 2'd2;
	localparam logic [1:0] PH_RET   = 2'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                ovf_q;
	logic                last_q;
	logic                chk_s1;
	logic                emit_rd_q;
	logic                out_valid_q;

	logic [CYL_BITS-1:0] val_q;
	logic [CNT_W-1:0]    j_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    split_q;
	logic [1:0]          phase_q;
	logic [ADDR_W-1:0]   ptr_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CYL_BITS-1:0] cur_q;
	logic [MOV_W-1:0]    mov_q;
	logic [CYL_BITS-1:0] out_pos_q;
	logic [MOV_W-1:0]    out_mov_q;
	logic                out_drop_q;
	logic                out_fin_q;

	logic                acc;
	logic                room;
	logic                place;
	logic [CYL_BITS-1:0] sat_rd;
	logic                below;
	logic [CNT_W-1:0]    asc_len;
	logic [CNT_W-1:0]    first_len;
	logic [CNT_W-1:0]    ret_len;
	logic [CNT_W-1:0]    split_m1;
	logic [CNT_W-1:0]    j_m2;
	logic [CNT_W-1:0]    cnt_m1;
	logic [ADDR_W-1:0]   first_start;
	logic [ADDR_W-1:0]   ret_start;
	logic                run_down;
	logic                needs_mem;
	logic                have;
	logic                out_free;
	logic                emit_go;
	logic                fin;
	logic [CYL_BITS-1:0] slot_pos;
	logic [CYL_BITS-1:0] diff;
	logic [MOV_W-1:0]    mov_nx;

	// Handshake and insertion decisions
	assign req.ready = (state_q == S_LOAD);
	assign acc       = req.valid && req.ready;
	assign room      = (cnt_q < CNT_MAX);
	assign place     = (j_q == '0) || !(rdata > val_q);
	assign cnt_m1    = cnt_q - CNT_ONE;
	assign j_m2      = j_q - CNT_TWO;

	// Saturated store data and split test
	assign sat_rd = (rdata > cfg.end_cyl) ? cfg.end_cyl : rdata;
	assign below  = cfg.right ? (sat_rd < cfg.head) : !(sat_rd > cfg.head);

	// Runs: entries below the split descend, the rest ascend
	assign asc_len     = cnt_q - split_q;
	assign split_m1    = split_q - CNT_ONE;
	assign first_len   = cfg.right ? asc_len : split_q;
	assign ret_len     = cfg.right ? split_q : asc_len;
	assign first_start = cfg.right ? split_q[ADDR_W-1:0] : split_m1[ADDR_W-1:0];
	assign ret_start   = cfg.right ? split_m1[ADDR_W-1:0] : split_q[ADDR_W-1:0];
	assign run_down    = (phase_q == PH_FIRST) ? !cfg.right : cfg.right;

	// Current slot of the sequence
	assign needs_mem = phase_q inside {PH_FIRST, PH_RET};
	assign have      = !needs_mem || emit_rd_q;
	assign out_free  = !out_valid_q || res.ready;
	assign emit_go   = (state_q == S_EMIT) && have && out_free;
	assign fin       = ((phase_q == PH_END) && (ret_len == '0)) ||
		((phase_q == PH_RET) && (rem_q == CNT_ONE));

	always_comb begin
		case (phase_q)
			PH_HEAD: slot_pos = cfg.head;
			PH_END:  slot_pos = cfg.right ? cfg.end_cyl : '0;
			default: slot_pos = sat_rd;
		endcase
	end

	assign diff   = (cur_q > slot_pos) ? (cur_q - slot_pos) : (slot_pos - cur_q);
	assign mov_nx = mov_q + MOV_W'(diff);

	// Store port control
	always_comb begin
		wr = '0;
		rd = '0;
		case (state_q)
			S_LOAD: begin
				if (acc && room) begin
					if (cnt_q == '0) begin
						wr.we   = 1'b1;
						wr.addr = '0;
						wr.data = req.cylinder;
					end else begin
						rd.re   = 1'b1;
						rd.addr = cnt_m1[ADDR_W-1:0];
					end
				end
			end
			S_INS: begin
				wr.we   = 1'b1;
				wr.addr = j_q[ADDR_W-1:0];
				wr.data = place ? val_q : rdata;
				if (!place && (j_q >= CNT_TWO)) begin
					rd.re   = 1'b1;
					rd.addr = j_m2[ADDR_W-1:0];
				end
			end
			S_CNT: begin
				if (idx_q < cnt_q) begin
					rd.re   = 1'b1;
					rd.addr = idx_q[ADDR_W-1:0];
				end
			end
			S_EMIT: begin
				if (needs_mem && !emit_rd_q) begin
					rd.re   = 1'b1;
					rd.addr = ptr_q;
				end
			end
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			chk_s1      <= 1'b0;
			emit_rd_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					chk_s1 <= 1'b0;
					if (acc) begin
						if (!room) begin
							ovf_q <= 1'b1;
							if (req.last_request) begin
								state_q <= S_CNT;
							end
						end else if (cnt_q == '0) begin
							cnt_q <= CNT_ONE;
							if (req.last_request) begin
								state_q <= S_CNT;
							end
						end else begin
							state_q <= S_INS;
						end
					end
				end
				S_INS: begin
					chk_s1 <= 1'b0;
					if (place) begin
						cnt_q   <= cnt_q + CNT_ONE;
						state_q <= last_q ? S_CNT : S_LOAD;
					end
				end
				S_CNT: begin
					chk_s1    <= (idx_q < cnt_q);
					emit_rd_q <= 1'b0;
					if ((idx_q == cnt_q) && !chk_s1) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (needs_mem && !emit_rd_q) begin
						emit_rd_q <= 1'b1;
					end
					if (emit_go) begin
						emit_rd_q <= 1'b0;
						if (fin) begin
							state_q <= S_LOAD;
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				idx_q   <= '0;
				split_q <= '0;
				if (acc) begin
					last_q <= req.last_request;
					val_q  <= req.cylinder;
					j_q    <= cnt_q;
				end
			end
			S_INS: begin
				idx_q   <= '0;
				split_q <= '0;
				if (!place) begin
					j_q <= j_q - CNT_ONE;
				end
			end
			S_CNT: begin
				if (idx_q < cnt_q) begin
					idx_q <= idx_q + CNT_ONE;
				end
				if (chk_s1 && below) begin
					split_q <= split_q + CNT_ONE;
				end
				phase_q <= PH_HEAD;
				cur_q   <= cfg.head;
				mov_q   <= '0;
			end
			S_EMIT: begin
				if (emit_go) begin
					cur_q <= slot_pos;
					mov_q <= mov_nx;
					case (phase_q)
						PH_HEAD: begin
							if (first_len != '0) begin
								phase_q <= PH_FIRST;
								ptr_q   <= first_start;
								rem_q   <= first_len;
							end else begin
								phase_q <= PH_END;
							end
						end
						PH_END: begin
							phase_q <= PH_RET;
							ptr_q   <= ret_start;
							rem_q   <= ret_len;
						end
						default: begin
							if ((phase_q == PH_FIRST) && (rem_q == CNT_ONE)) begin
								phase_q <= PH_END;
							end else begin
								rem_q <= rem_q - CNT_ONE;
								ptr_q <= run_down ? (ptr_q - 1'b1) : (ptr_q + 1'b1);
							end
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_pos_q  <= slot_pos;
			out_mov_q  <= mov_nx;
			out_drop_q <= ovf_q;
			out_fin_q  <= fin;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.position       = out_pos_q;
	assign res.total_movement = out_mov_q;
	assign res.dropped        = out_drop_q;
	assign res.final_step     = out_fin_q;

	assign stat.sched = (state_q == S_CNT) || (state_q == S_EMIT);
	assign stat.cnt   = cnt_q;
endmodule

FILE: hw/rtl/scan_disk_scheduler.sv
// SCAN disk scheduler top level: configuration registers, request store
// and controller. Depends on sds_pkg, sds_in_if, sds_out_if, sds_store, sds_ctrl.
//
//   channel   direction  handshake            payload
//   req       in         valid/ready          cylinder, last_request
//   res       out        valid/ready          position, total_movement, dropped, final_step
//   cfg       in         cfg_we (no ready)    cfg_idx, cfg_wdata
//
// A request taken while the store holds entries is inserted in sorted order,
// shifting one store entry per cycle; into an empty store it is written directly.
// After the last request the split point is found with one store read per
// entry, then the n+2 results follow: head, first run, far end, return run. A
// result from the store waits for its registered read, and any result waits
// while the output stalls.
// Reset clears the control state and loads disk_size 200, start_head 0 and
// sweep_right 1; the store itself is not cleared.
module scan_disk_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	sds_in_if.sink                         req,
	sds_out_if.source                      res,
	input  logic                           cfg_we,
	input  logic [sds_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [sds_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import sds_pkg::*;

	logic [SIZE_W-1:0]   disk_size_q;
	logic [CYL_BITS-1:0] start_head_q;
	logic                sweep_right_q;
	sds_cfg_t            cfg;
	sds_wr_t             wr;
	sds_rd_t             rd;
	sds_stat_t           stat;
	logic [CYL_BITS-1:0] rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_size_q   <= SIZE_W'(200);
			start_head_q  <= '0;
			sweep_right_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DISK_SIZE:   disk_size_q   <= cfg_wdata[SIZE_W-1:0];
				REG_START_HEAD:  start_head_q  <= cfg_wdata[CYL_BITS-1:0];
				REG_SWEEP_RIGHT: sweep_right_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Far end of the disk: size 0 acts as 1, sizes above 65536 clamp
	always_comb begin
		if (disk_size_q == '0) begin
			cfg.end_cyl = '0;
		end else if (disk_size_q[SIZE_W-1]) begin
			cfg.end_cyl = '1;
		end else begin
			cfg.end_cyl = disk_size_q[CYL_BITS-1:0] - 1'b1;
		end
		cfg.head  = start_head_q;
		cfg.right = sweep_right_q;
	end

	sds_store u_store (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

	sds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.res    (res),
		.wr     (wr),
		.rd     (rd),
		.rdata  (rdata),
		.stat   (stat)
	);

	// Fill count never passes the store depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.cnt <= CNT_W'(MAX_REQUESTS))
		else $error("request count above store depth");

	// A request taken into an empty store is counted at once
	a_first_req: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && (stat.cnt == '0) |=> stat.cnt == CNT_W'(1))
		else $error("first request not counted");

	// Scheduling always works on a nonempty batch
	a_sched_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		stat.sched |-> stat.cnt != '0)
		else $error("scheduling with an empty store");
endmodule
